@@ hdl/tlbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths and the command/status bundles between the translator's
// controller and datapath.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int unsigned VA_W = 16;  // virtual address width
  localparam int unsigned PA_W = 15;  // physical address width

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // write one cleared page table entry, bump sweep index
    logic latch_in;   // capture the incoming virtual address
    logic do_div;     // register quotient of page field by page count
    logic do_page;    // register page number (remainder)
    logic do_cmp;     // register TLB tag match vector
    logic sel;        // take TLB lookup result (hit flag, matched frame)
    logic rd_tables;  // read page table and frame owner table
    logic take_pt;    // frame comes from the page table read data
    logic unmap;      // clear mapping of the page that owned the victim frame
    logic map;        // map page to victim frame, advance frame pointer
    logic fill;       // write page/frame into TLB slot, advance fill pointer
    logic load_out;   // load result registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;   // sweep index is at the last page table entry
    logic hit;        // some valid TLB entry matched
    logic pt_mapped;  // page table read data says page is mapped
    logic wrapped;    // frame pointer has wrapped at least once
  } sts_t;

endpackage

@@ hdl/tlbpt_ram.sv @@
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tlbpt_datapath.sv @@
// ----------------------------------------------------------------------------
// tlbpt_datapath
// Address split, page number reduction, TLB, page table, frame owner table,
// frame and fill pointers and result registers.
// ----------------------------------------------------------------------------
module tlbpt_datapath
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned NUM_PAGES   = 256,
  parameter int unsigned NUM_FRAMES  = 128,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [VA_W-1:0] virtual_address_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic [PA_W-1:0] physical_address_o,
  output logic            tlb_hit_o,
  output logic            page_fault_o
);

  localparam int unsigned PIN_W   = (VA_W > OFFSET_BITS) ? VA_W - OFFSET_BITS : 1;
  localparam int unsigned PAGE_W  = $clog2(NUM_PAGES);
  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam int unsigned TIDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned PT_W    = FRAME_W + 1;
  // reciprocal for the page count; exact for dividends below 2**12
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP    = (32'd1 << RECIP_SH) / NUM_PAGES + 1;

  logic [VA_W-1:0]    va_q;
  logic [PIN_W-1:0]   quo_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;
  logic               hit_q, fault_q;

  logic [PAGE_W-1:0]  clr_q, clr_d;
  logic [FRAME_W-1:0] next_q, next_d;
  logic               wrapped_q, wrapped_d;
  logic [TIDX_W-1:0]  fill_q, fill_d;

  logic [PAGE_W-1:0]  tlb_tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_q, tlb_valid_d;
  logic [TLB_ENTRIES-1:0] match_q;

  logic [PA_W-1:0] pa_q;
  logic            hit_out_q, fault_out_q;

  // page number reduction
  logic [VA_W-1:0]  va_shift;
  logic [PIN_W-1:0] pfield;
  logic [47:0]      quo_prod;
  logic [31:0]      rem_full;
  assign va_shift = va_q >> OFFSET_BITS;
  assign pfield   = va_shift[PIN_W-1:0];
  assign quo_prod = 48'(pfield) * 48'(RECIP);
  assign rem_full = 32'(pfield) - 32'(quo_q) * 32'(NUM_PAGES);

  // TLB lookup
  logic [TLB_ENTRIES-1:0] match_d;
  logic [FRAME_W-1:0]     tlb_frame_sel;
  always_comb begin
    tlb_frame_sel = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_d[i] = tlb_valid_q[i] && (tlb_tag_q[i] == page_q);
      if (match_q[i]) begin
        tlb_frame_sel = tlb_frame_sel | tlb_frame_q[i];
      end
    end
  end

  // tables
  logic              pt_we;
  logic [PAGE_W-1:0] pt_waddr;
  logic [PT_W-1:0]   pt_wdata, pt_rdata;
  logic [PAGE_W-1:0] owner_rdata;

  assign pt_we    = cmd_i.clr_step | cmd_i.unmap | cmd_i.map;
  assign pt_waddr = cmd_i.clr_step ? clr_q : (cmd_i.unmap ? owner_rdata : page_q);
  assign pt_wdata = cmd_i.map ? {1'b1, next_q} : '0;

  tlbpt_ram #(.WIDTH(PT_W), .DEPTH(NUM_PAGES)) u_page_table (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (cmd_i.rd_tables),
    .raddr_i (page_q),
    .rdata_o (pt_rdata)
  );

  tlbpt_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_FRAMES)) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (cmd_i.map),
    .waddr_i (next_q),
    .wdata_i (page_q),
    .re_i    (cmd_i.rd_tables),
    .raddr_i (next_q),
    .rdata_o (owner_rdata)
  );

  // pointers and valid bits
  always_comb begin
    clr_d       = clr_q;
    next_d      = next_q;
    wrapped_d   = wrapped_q;
    fill_d      = fill_q;
    tlb_valid_d = tlb_valid_q;
    if (cmd_i.clr_step) begin
      clr_d = clr_q + 1'b1;
    end
    if (cmd_i.map) begin
      if (next_q == FRAME_W'(NUM_FRAMES - 1)) begin
        next_d    = '0;
        wrapped_d = 1'b1;
      end else begin
        next_d = next_q + 1'b1;
      end
    end
    if (cmd_i.fill) begin
      tlb_valid_d[fill_q] = 1'b1;
      if (fill_q == TIDX_W'(TLB_ENTRIES - 1)) begin
        fill_d = '0;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      next_q      <= '0;
      wrapped_q   <= 1'b0;
      fill_q      <= '0;
      tlb_valid_q <= '0;
    end else begin
      clr_q       <= clr_d;
      next_q      <= next_d;
      wrapped_q   <= wrapped_d;
      fill_q      <= fill_d;
      tlb_valid_q <= tlb_valid_d;
    end
  end

  // payload registers
  logic [VA_W-1:0] offset;
  logic [31:0]     pa_full;
  assign offset  = va_q & VA_W'((32'd1 << OFFSET_BITS) - 1);
  assign pa_full = (32'(frame_q) << OFFSET_BITS) | 32'(offset);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) va_q <= virtual_address_i;
    if (cmd_i.do_div)   quo_q <= PIN_W'(quo_prod >> RECIP_SH);
    if (cmd_i.do_page)  page_q <= PAGE_W'(rem_full);
    if (cmd_i.do_cmp)   match_q <= match_d;
    if (cmd_i.sel) begin
      hit_q   <= |match_q;
      fault_q <= 1'b0;
      frame_q <= tlb_frame_sel;
    end
    if (cmd_i.take_pt) frame_q <= pt_rdata[FRAME_W-1:0];
    if (cmd_i.map) begin
      frame_q <= next_q;
      fault_q <= 1'b1;
    end
    if (cmd_i.fill) begin
      tlb_tag_q[fill_q]   <= page_q;
      tlb_frame_q[fill_q] <= frame_q;
    end
    if (cmd_i.load_out) begin
      pa_q        <= pa_full[PA_W-1:0];
      hit_out_q   <= hit_q;
      fault_out_q <= fault_q;
    end
  end

  assign sts_o.clr_last  = (clr_q == PAGE_W'(NUM_PAGES - 1));
  assign sts_o.hit       = |match_q;
  assign sts_o.pt_mapped = pt_rdata[FRAME_W];
  assign sts_o.wrapped   = wrapped_q;

  assign physical_address_o = pa_q;
  assign tlb_hit_o          = hit_out_q;
  assign page_fault_o       = fault_out_q;

endmodule

@@ hdl/tlbpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer for one translation: clear sweep, lookup, miss handling, result.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_PAGE  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_SEL   = 4'd5;
  localparam logic [3:0] S_PTRD  = 4'd6;
  localparam logic [3:0] S_MAP   = 4'd7;
  localparam logic [3:0] S_FILL  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.do_div = 1'b1;
        state_d      = S_PAGE;
      end
      S_PAGE: begin
        cmd_o.do_page = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        cmd_o.do_cmp = 1'b1;
        state_d      = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        if (sts_i.hit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_tables = 1'b1;
          state_d         = S_PTRD;
        end
      end
      S_PTRD: begin
        if (sts_i.pt_mapped) begin
          cmd_o.take_pt = 1'b1;
          state_d       = S_FILL;
        end else begin
          cmd_o.unmap = sts_i.wrapped;
          state_d     = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tlb_page_table_translator.sv @@
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical address translation with a TLB, a page table and
// FIFO frame replacement.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The virtual address splits into a
// page number (high bits, reduced modulo NUM_PAGES) and an OFFSET_BITS offset.
// The page is searched in a fully associative TLB of TLB_ENTRIES entries. On a
// miss the page table RAM is read; an unmapped page takes the frame at the
// FIFO frame pointer, and once that pointer has wrapped the page that last
// owned the frame loses its mapping. Every miss fills the TLB round robin.
// TLB entries are not invalidated when their frame is reused, so a stale
// entry keeps hitting with its old frame. One address is in flight at a time:
// after acceptance the page field is reduced by a reciprocal multiply and a
// page subtract, the tags are compared in a registered step and the match is
// selected; a miss then reads the page table and frame owner RAMs, a page
// fault unmaps and maps through the single write port of the page table, and
// the TLB is filled. The result is loaded once the output register is free,
// and the next address can be taken from the same cycle on in which the result
// is presented. A finished result sits in an output register, and the next
// address is accepted while it waits. After reset the page table is cleared in
// a sweep over all NUM_PAGES entries, during which no address is accepted.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned NUM_PAGES   = 256,
  parameter int unsigned NUM_FRAMES  = 128,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // address transaction
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [VA_W-1:0] virtual_address_i,
  // result transaction
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PA_W-1:0] physical_address_o,
  output logic            tlb_hit_o,
  output logic            page_fault_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: clear sweep, lookup steps, miss handling, output handshake
  tlbpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .NUM_PAGES   (NUM_PAGES),
    .NUM_FRAMES  (NUM_FRAMES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .virtual_address_i  (virtual_address_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o)
  );

endmodule
